>>> sv/biq_pkg.sv
// Shared constants for the biquad filter: default widths and register map.
`timescale 1ns / 1ps
`default_nettype none
package biq_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_BITS_DEF      = 24;
    localparam int COEF_FRAC_BITS_DEF = 20;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    typedef logic [REG_IDX_BITS-1:0] t_reg_idx;

    localparam t_reg_idx REG_B0 = 3'd0;
    localparam t_reg_idx REG_B1 = 3'd1;
    localparam t_reg_idx REG_B2 = 3'd2;
    localparam t_reg_idx REG_A1 = 3'd3;
    localparam t_reg_idx REG_A2 = 3'd4;

endpackage
`default_nettype wire

>>> sv/biq_regs.sv
// Coefficient register file behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none
module biq_regs #(
    parameter int COEF_BITS      = biq_pkg::COEF_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [biq_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [biq_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [biq_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready,
    output logic signed [COEF_BITS-1:0]             o_coef_b0,
    output logic signed [COEF_BITS-1:0]             o_coef_b1,
    output logic signed [COEF_BITS-1:0]             o_coef_b2,
    output logic signed [COEF_BITS-1:0]             o_coef_a1,
    output logic signed [COEF_BITS-1:0]             o_coef_a2,
    output logic                                    o_hist_clear
);

    // Unity gain, or the largest positive coefficient when unity does not fit.
    localparam logic signed [COEF_BITS-1:0] B0_RESET =
        (COEF_FRAC_BITS >= COEF_BITS - 1) ? {1'b0, {(COEF_BITS-1){1'b1}}}
                                          : (COEF_BITS'(1) << COEF_FRAC_BITS);

    logic signed [COEF_BITS-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic                        wr_en;
    biq_pkg::t_reg_idx           idx;
    logic                        idx_ok;
    logic signed [COEF_BITS-1:0] wdata;

    assign pready = 1'b1;
    assign idx    = paddr[biq_pkg::APB_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign wdata  = pwdata[COEF_BITS-1:0];

    always_comb begin
        case (idx)
            biq_pkg::REG_B0, biq_pkg::REG_B1, biq_pkg::REG_B2,
            biq_pkg::REG_A1, biq_pkg::REG_A2: idx_ok = 1'b1;
            default:                          idx_ok = 1'b0;
        endcase
    end

    // A write to any listed register restarts the filter history.
    assign o_hist_clear = wr_en && idx_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= B0_RESET;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (wr_en) begin
            case (idx)
                biq_pkg::REG_B0: r_b0 <= wdata;
                biq_pkg::REG_B1: r_b1 <= wdata;
                biq_pkg::REG_B2: r_b2 <= wdata;
                biq_pkg::REG_A1: r_a1 <= wdata;
                biq_pkg::REG_A2: r_a2 <= wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            biq_pkg::REG_B0: prdata = biq_pkg::APB_DATA_BITS'(r_b0);
            biq_pkg::REG_B1: prdata = biq_pkg::APB_DATA_BITS'(r_b1);
            biq_pkg::REG_B2: prdata = biq_pkg::APB_DATA_BITS'(r_b2);
            biq_pkg::REG_A1: prdata = biq_pkg::APB_DATA_BITS'(r_a1);
            biq_pkg::REG_A2: prdata = biq_pkg::APB_DATA_BITS'(r_a2);
            default:         prdata = '0;
        endcase
    end

    assign o_coef_b0 = r_b0;
    assign o_coef_b1 = r_b1;
    assign o_coef_b2 = r_b2;
    assign o_coef_a1 = r_a1;
    assign o_coef_a2 = r_a2;

endmodule
`default_nettype wire

>>> sv/biq_core.sv
// Input register, five-tap multiply-accumulate with history, and result register.
`timescale 1ns / 1ps
`default_nettype none
module biq_core #(
    parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = biq_pkg::COEF_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_b0,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_b1,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_b2,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_a1,
    input  wire logic signed [COEF_BITS-1:0]   i_coef_a2,
    input  wire logic                          i_hist_clear
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMAX  =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SMIN  = ~SMAX;

    logic                          r_in_vld, n_in_vld;
    logic signed [SAMPLE_BITS-1:0] r_in_x;
    logic                          r_out_vld, n_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_y;
    logic signed [SAMPLE_BITS-1:0] r_x1, r_x2, r_y1, r_y2;

    logic                          out_free, fire, in_take;
    logic signed [PROD_W-1:0]      p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]       acc, acc_sh;
    logic signed [SAMPLE_BITS-1:0] y;

    // The result register frees up either when empty or when its word leaves.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign p_b0 = r_in_x * i_coef_b0;
    assign p_b1 = r_x1   * i_coef_b1;
    assign p_b2 = r_x2   * i_coef_b2;
    assign p_a1 = r_y1   * i_coef_a1;
    assign p_a2 = r_y2   * i_coef_a2;

    // Exact sum, round half up, then an arithmetic shift back to sample scale.
    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND;
    assign acc_sh = acc >>> COEF_FRAC_BITS;

    always_comb begin
        if (acc_sh > SMAX) begin
            y = SMAX[SAMPLE_BITS-1:0];
        end else if (acc_sh < SMIN) begin
            y = SMIN[SAMPLE_BITS-1:0];
        end else begin
            y = acc_sh[SAMPLE_BITS-1:0];
        end
    end

    assign n_in_vld  = in_take || (r_in_vld && !fire);
    assign n_out_vld = fire || (r_out_vld && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_x <= i_sample_in;
        end
        if (fire) begin
            r_out_y <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_hist_clear) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (fire) begin
            r_x1 <= r_in_x;
            r_x2 <= r_x1;
            r_y1 <= y;
            r_y2 <= r_y1;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_y;

endmodule
`default_nettype wire

>>> sv/biquad_iir_filter_top.sv
// Top level of the direct form I biquad filter.
//
//   channel   direction  handshake                    word
//   input     in         i_in_valid / o_in_stall      i_sample_in
//   output    out        o_out_valid / i_out_stall    o_sample_out
//   config    in         psel, penable, pwrite        paddr, pwdata, prdata
//
// One word per cycle is sustained while the output is not stalled; a word reaches the
// output through the input register and then the result register.
// The five multipliers and the accumulator close the feedback through the output
// history combinationally, which sets that rate.
// Reset (synchronous, active low) loads unity gain and clears the history.
// A stall on the output holds the result register and then the input register.
`timescale 1ns / 1ps
`default_nettype none
module biquad_iir_filter_top #(
    parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = biq_pkg::COEF_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]           o_sample_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [biq_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [biq_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [biq_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready
);

    logic signed [COEF_BITS-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic                        hist_clear;

    biq_regs #(
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_coef_b0    (coef_b0),
        .o_coef_b1    (coef_b1),
        .o_coef_b2    (coef_b2),
        .o_coef_a1    (coef_a1),
        .o_coef_a2    (coef_a2),
        .o_hist_clear (hist_clear)
    );

    biq_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_coef_b0    (coef_b0),
        .i_coef_b1    (coef_b1),
        .i_coef_b2    (coef_b2),
        .i_coef_a1    (coef_a1),
        .i_coef_a2    (coef_a2),
        .i_hist_clear (hist_clear)
    );

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the direct form I biquad filter top level.
`timescale 1ns / 1ps
module tb;

    localparam int SW = biq_pkg::SAMPLE_BITS_DEF;
    localparam int CW = biq_pkg::COEF_BITS_DEF;
    localparam int CF = biq_pkg::COEF_FRAC_BITS_DEF;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [CW-1:0] COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COEF_MIN   = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COEF_HALF  = CW'(1) << (CF - 1);
    localparam logic signed [CW-1:0] COEF_QUARTER = CW'(1) << (CF - 2);
    localparam logic signed [CW-1:0] COEF_UNITY =
        (CF >= CW - 1) ? COEF_MAX : (CW'(1) << CF);

    localparam longint OUT_MAX    = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint OUT_MIN    = -OUT_MAX - 1;
    localparam longint ROUND_HALF = 64'sd1 <<< (CF - 1);

    localparam int NUM_COEFS      = biq_pkg::REG_A2 + 1;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 106;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic signed [SW-1:0] i_sample_in = '0;
    logic i_out_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [biq_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [biq_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [SW-1:0] o_sample_out;
    logic [biq_pkg::APB_DATA_BITS-1:0] prdata;
    logic pready;

    biquad_iir_filter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Filter state as the testbench sees it.
    logic signed [CW-1:0] coef [NUM_COEFS];
    logic signed [SW-1:0] in_hist1, in_hist2, out_hist1, out_hist2;

    logic signed [SW-1:0] pending_samples [$];
    logic signed [SW-1:0] expected_samples [$];

    bit quiet = 1'b0;
    int errors = 0;
    int words_in = 0;
    int words_checked = 0;
    int coef_writes = 0;
    int settings = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int in_calm = 0;
    int out_burst = 0;
    int out_calm = 0;

    function automatic logic signed [SW-1:0] biquad_response(input logic signed [SW-1:0] x);
        logic signed [63:0] cw [NUM_COEFS];
        logic signed [63:0] xw, x1w, x2w, y1w, y2w;
        logic signed [63:0] acc;
        for (int k = 0; k < NUM_COEFS; k++)
            cw[biq_pkg::t_reg_idx'(k)] = coef[biq_pkg::t_reg_idx'(k)];
        xw = x;
        x1w = in_hist1;
        x2w = in_hist2;
        y1w = out_hist1;
        y2w = out_hist2;
        acc = cw[biq_pkg::REG_B0] * xw + cw[biq_pkg::REG_B1] * x1w
            + cw[biq_pkg::REG_B2] * x2w - cw[biq_pkg::REG_A1] * y1w
            - cw[biq_pkg::REG_A2] * y2w + ROUND_HALF;
        acc = acc >>> CF;
        if (acc > OUT_MAX)
            return SAMPLE_MAX;
        if (acc < OUT_MIN)
            return SAMPLE_MIN;
        return SW'(acc);
    endfunction

    function automatic logic signed [CW-1:0] draw_coef(input int style);
        case (style)
            0: return CW'($urandom());
            1: return CW'($urandom_range(0, 2 ** CF) - 2 ** (CF - 1));
            default: begin
                case ($urandom_range(0, 4))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return '0;
                    3: return '1;
                    default: return CW'($urandom());
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [SW-1:0] draw_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        if (pick <= 3)
            return SW'($urandom_range(0, 510) - 255);
        return SW'($urandom());
    endfunction

    task automatic write_coef(input biq_pkg::t_reg_idx idx,
                              input logic signed [CW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= biq_pkg::APB_DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Only mapped registers touch the filter; unmapped writes keep the history.
        if (idx <= biq_pkg::REG_A2) begin
            coef[idx] = value;
            in_hist1  = '0;
            in_hist2  = '0;
            out_hist1 = '0;
            out_hist2 = '0;
        end
        coef_writes++;
    endtask

    task automatic check_coefs();
        for (int k = 0; k < NUM_COEFS; k++) begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {biq_pkg::t_reg_idx'(k), 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata[CW-1:0] !== coef[biq_pkg::t_reg_idx'(k)]) begin
                $display("%0t: register %0d read mismatch: expected %h, got %h",
                         $time, k, coef[biq_pkg::t_reg_idx'(k)], prdata[CW-1:0]);
                errors++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic set_coefs(input logic signed [CW-1:0] b0, input logic signed [CW-1:0] b1,
                             input logic signed [CW-1:0] b2, input logic signed [CW-1:0] a1,
                             input logic signed [CW-1:0] a2);
        write_coef(biq_pkg::REG_B0, b0);
        write_coef(biq_pkg::REG_B1, b1);
        write_coef(biq_pkg::REG_B2, b2);
        write_coef(biq_pkg::REG_A1, a1);
        write_coef(biq_pkg::REG_A2, a2);
        check_coefs();
        settings++;
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || expected_samples.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Source side: presents queued words, with random gaps between them.
    always @(posedge i_clk) begin : source_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                pending_samples.delete(0);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0 && !quiet) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_samples.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!quiet && in_calm == 0 && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 13);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid  <= 1'b1;
                    i_sample_in <= pending_samples[0];
                end
            end
            if (in_calm > 0)
                in_calm--;
            else if ($urandom_range(0, 39) == 0)
                in_calm = $urandom_range(20, 80);
        end
    end

    // Sink side: stalls the output in random bursts.
    always @(posedge i_clk) begin : sink_pacing
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            out_burst = 0;
        end else if (out_burst > 0) begin
            out_burst--;
            i_out_stall <= 1'b1;
        end else if (out_calm == 0 && $urandom_range(0, 6) == 0) begin
            out_burst = $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
        if (out_calm > 0)
            out_calm--;
        else if ($urandom_range(0, 49) == 0)
            out_calm = $urandom_range(20, 80);
    end

    always @(posedge i_clk) begin : monitor
        logic signed [SW-1:0] want;
        logic took;
        if (i_rst_n) begin
            took = 1'b0;
            // The output is checked before the input is predicted, so a spurious word
            // can never be matched against the one just taken.
            if (o_out_valid && !i_out_stall) begin
                took = 1'b1;
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected output word: expected none, got %0d",
                             $time, o_sample_out);
                    errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (o_sample_out !== want) begin
                        $display("%0t: sample_out mismatch: expected %0d, got %0d",
                                 $time, want, o_sample_out);
                        errors++;
                    end
                    words_checked++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                took = 1'b1;
                want = biquad_response(i_sample_in);
                in_hist2  = in_hist1;
                in_hist1  = i_sample_in;
                out_hist2 = out_hist1;
                out_hist1 = want;
                expected_samples.push_back(want);
                words_in++;
            end
            idle_cycles = took ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("biquad_iir_filter_top test failed");
                $finish;
            end
        end
    end

    initial begin : sequencer
        int style;
        coef[biq_pkg::REG_B0] = COEF_UNITY;
        for (int k = biq_pkg::REG_B1; k < NUM_COEFS; k++)
            coef[biq_pkg::t_reg_idx'(k)] = '0;
        in_hist1  = '0;
        in_hist2  = '0;
        out_hist1 = '0;
        out_hist2 = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: unity gain passes every sample through unchanged.
        check_coefs();
        settings++;
        @(negedge i_clk);
        pending_samples = '{'0, SAMPLE_MAX, SAMPLE_MIN, SW'(1), '1,
                            SW'(24'h555555), SW'(24'hAAAAAA)};
        drain();

        // Largest gains of alternating sign drive the output into both rails.
        set_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        @(negedge i_clk);
        pending_samples = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, '0};
        drain();

        set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        @(negedge i_clk);
        pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, SW'(1), '1};
        drain();

        // A gain of one half puts odd samples exactly on a rounding tie.
        set_coefs(COEF_HALF, '0, '0, '0, '0);
        @(negedge i_clk);
        pending_samples = '{SW'(1), '1, SW'(3), -SW'(3)};
        drain();

        // Writes to unmapped addresses must leave the history alone.
        set_coefs(COEF_HALF, COEF_QUARTER, -COEF_QUARTER, -COEF_HALF, COEF_QUARTER);
        @(negedge i_clk);
        pending_samples = '{SW'(1000), -SW'(2000), SW'(3000)};
        drain();
        for (int k = biq_pkg::REG_A2 + 1; k < 2 ** biq_pkg::REG_IDX_BITS; k++)
            write_coef(biq_pkg::t_reg_idx'(k), CW'($urandom()));
        check_coefs();
        @(negedge i_clk);
        pending_samples = '{SW'(500), '0, -SW'(700)};
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            style = p % 3;
            quiet = (p == RANDOM_PHASES - 1);
            if (p == 0) begin
                set_coefs(draw_coef(style), draw_coef(style), draw_coef(style),
                          draw_coef(style), draw_coef(style));
            end else begin
                // Rewrite a random subset; any single write restarts the history.
                for (int k = 0; k < NUM_COEFS; k++)
                    if ($urandom_range(0, 1) == 1)
                        write_coef(biq_pkg::t_reg_idx'(k), draw_coef(style));
                check_coefs();
                settings++;
            end
            @(negedge i_clk);
            for (int n = 0; n < PHASE_WORDS; n++)
                pending_samples.push_back(draw_sample());
            drain();
        end

        $display("Sent %0d input words and checked %0d output words over %0d coefficient settings",
                 words_in, words_checked, settings);
        $display("with %0d register writes, unmapped writes, rounding ties and saturation included.",
                 coef_writes);
        if (errors == 0) begin
            $display("biquad_iir_filter_top test passed");
        end else begin
            $display("biquad_iir_filter_top test failed");
        end
        $finish;
    end

endmodule

>>> biquad_iir_filter_top.f
sv/biq_pkg.sv
sv/biq_regs.sv
sv/biq_core.sv
sv/biquad_iir_filter_top.sv
dv/tb.sv
